[hdl/tmw_pkg.sv]
// Shared constants and result codes for the timing wheel server dispatcher.
package tmw_pkg;

  // Default sizes of the storage
  localparam int MAX_SLOTS_DEF   = 256;
  localparam int NUM_SERVERS_DEF = 8;
  localparam int REQ_DEPTH_DEF   = 16;

  // Field widths
  localparam int KIND_W   = 3;
  localparam int TAG_W    = 16;
  localparam int DUR_W    = 16;
  localparam int SRVID_W  = 3;
  localparam int SLOT_W   = 8;
  localparam int MD_W     = 9;
  localparam int NS_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;
  localparam int MOD_W    = 17;

  // Register reset values
  localparam logic [MD_W-1:0] MAX_DELAY_RST   = 9'd64;
  localparam logic [NS_W-1:0] NUM_SERVERS_RST = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERVERS = 1'b1;

  // Request codes
  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RETIRED    = 3'd0,
    KIND_DISPATCHED = 3'd1,
    KIND_DONE       = 3'd2,
    KIND_ACCEPTED   = 3'd3,
    KIND_REJECTED   = 3'd4
  } kind_e;

endpackage

[hdl/timing_wheel_server_dispatcher.sv]
// Timing wheel that pairs queued jobs with free servers, with a shared modulo unit.
// Sequence: a submit item is latched, then its accepted or rejected result is registered and
// the block returns to idle. A tick takes NUM_SERVERS retire steps, then per dispatched job a
// FIFO read, a 17-step remainder and placement, then a remainder for the slot advance and the
// done result; a stalled output holds every step that has a result to write.
// The bit-serial remainder unit sets the pace; one item is in work at a time.
// Reset: wheel empty, request FIFO empty, free FIFO holds all configured servers.
module timing_wheel_server_dispatcher import tmw_pkg::*; #(
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
  parameter int NUM_SERVERS = NUM_SERVERS_DEF,
  parameter int REQ_DEPTH   = REQ_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [DUR_W-1:0]     duration_i,
  input  logic [TAG_W-1:0]     query_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KIND_W-1:0]    kind_o,
  output logic [TAG_W-1:0]     job_tag_o,
  output logic [SRVID_W-1:0]   server_id_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 wheel_idle_o,
  output logic                 last_o
);

  localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W = $clog2(NUM_SERVERS + 1);
  localparam int RQ_W  = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
  localparam int RQC_W = $clog2(REQ_DEPTH + 1);
  localparam int MODC_W = $clog2(MOD_W + 1);
  localparam int RST_POOL = (NUM_SERVERS < int'(NUM_SERVERS_RST)) ? NUM_SERVERS
                                                                   : int'(NUM_SERVERS_RST);

  typedef enum logic [2:0] {
    S_IDLE, S_SUBMIT, S_RETIRE, S_DISP_CHK, S_DISP_LD, S_MOD, S_DISPATCH, S_DONE
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [MD_W-1:0] md_q, md_d;

  // Latched input item
  logic [DUR_W-1:0] dur_q, dur_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  // Wheel state
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  busy_q, busy_d;
  logic              ent_valid_q [NUM_SERVERS];
  logic              ent_valid_d [NUM_SERVERS];
  logic [SLOT_W-1:0] ent_slot_q [NUM_SERVERS];
  logic [SLOT_W-1:0] ent_slot_d [NUM_SERVERS];
  logic [TAG_W-1:0]  ent_tag_q [NUM_SERVERS];
  logic [TAG_W-1:0]  ent_tag_d [NUM_SERVERS];
  logic [SRV_W-1:0]  ent_ord_q [NUM_SERVERS];
  logic [SRV_W-1:0]  ent_ord_d [NUM_SERVERS];
  logic [SRV_W-1:0]  pos_q, pos_d;

  // Free server FIFO
  logic [SRV_W-1:0] free_q [NUM_SERVERS];
  logic [SRV_W-1:0] free_d [NUM_SERVERS];
  logic [SRV_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;

  // Request FIFO pointers and memory
  logic [RQ_W-1:0]  req_head_q, req_head_d;
  logic [RQC_W-1:0] req_cnt_q, req_cnt_d;
  logic [DUR_W+TAG_W-1:0] req_mem [REQ_DEPTH];
  logic [DUR_W+TAG_W-1:0] req_rd_q;
  logic                   mem_we;
  logic [RQ_W-1:0]        req_tail;

  // Remainder unit
  logic [MOD_W-1:0]  mod_num_q, mod_num_d;
  logic [MD_W-1:0]   mod_rem_q, mod_rem_d;
  logic [MODC_W-1:0] mod_cnt_q, mod_cnt_d;
  logic              mod_adv_q, mod_adv_d;
  logic [MD_W-1:0]   mod_m;
  logic [MD_W:0]     rem_shift;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [TAG_W-1:0]   otag_q, otag_d;
  logic [SRVID_W-1:0] osrv_q, osrv_d;
  logic [SLOT_W-1:0]  oslot_q, oslot_d;
  logic               oidle_q, oidle_d;
  logic               olast_q, olast_d;
  logic               out_free;

  // Helpers
  logic              ret_hit;
  logic [SRV_W-1:0]  ret_idx;
  logic [SRV_W-1:0]  disp_ord;
  logic [SRV_W-1:0]  free_tail;
  logic [SRV_W-1:0]  disp_srv;
  logic [CNT_W-1:0]  ns_eff_new;
  logic [SRV_W+1:0]  free_sum;
  logic [RQ_W+1:0]   req_sum;

  // Effective modulus
  always_comb begin
    if (md_q == '0) begin
      mod_m = MD_W'(1);
    end else if (32'(md_q) > MAX_SLOTS) begin
      mod_m = MD_W'(MAX_SLOTS);
    end else begin
      mod_m = md_q;
    end
  end

  // Effective pool size of a num_servers write
  always_comb begin
    if (cfg_data_i[NS_W-1:0] == '0) begin
      ns_eff_new = CNT_W'(1);
    end else if (32'(cfg_data_i[NS_W-1:0]) > NUM_SERVERS) begin
      ns_eff_new = CNT_W'(NUM_SERVERS);
    end else begin
      ns_eff_new = CNT_W'(cfg_data_i[NS_W-1:0]);
    end
  end

  // Find the entry of the current slot at the current position
  always_comb begin
    ret_hit = 1'b0;
    ret_idx = '0;
    for (int e = 0; e < NUM_SERVERS; e++) begin
      if (!ret_hit && ent_valid_q[e] && ent_slot_q[e] == cur_q && ent_ord_q[e] == pos_q) begin
        ret_hit = 1'b1;
        ret_idx = SRV_W'(e);
      end
    end
  end

  // Count entries already placed in the target slot
  always_comb begin
    disp_ord = '0;
    for (int e = 0; e < NUM_SERVERS; e++) begin
      if (ent_valid_q[e] && ent_slot_q[e] == mod_rem_q[SLOT_W-1:0]) begin
        disp_ord = disp_ord + SRV_W'(1);
      end
    end
  end

  // FIFO tails
  always_comb begin
    free_sum = (SRV_W+2)'(free_head_q) + (SRV_W+2)'(free_cnt_q);
    if (free_sum >= (SRV_W+2)'(NUM_SERVERS)) begin
      free_tail = SRV_W'(free_sum - (SRV_W+2)'(NUM_SERVERS));
    end else begin
      free_tail = SRV_W'(free_sum);
    end
    req_sum = (RQ_W+2)'(req_head_q) + (RQ_W+2)'(req_cnt_q);
    if (req_sum >= (RQ_W+2)'(REQ_DEPTH)) begin
      req_tail = RQ_W'(req_sum - (RQ_W+2)'(REQ_DEPTH));
    end else begin
      req_tail = RQ_W'(req_sum);
    end
  end

  assign disp_srv  = free_q[free_head_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rem_shift = {mod_rem_q, mod_num_q[MOD_W-1]};
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    md_d        = md_q;
    dur_d       = dur_q;
    tag_d       = tag_q;
    cur_d       = cur_q;
    busy_d      = busy_q;
    ent_valid_d = ent_valid_q;
    ent_slot_d  = ent_slot_q;
    ent_tag_d   = ent_tag_q;
    ent_ord_d   = ent_ord_q;
    pos_d       = pos_q;
    free_d      = free_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    req_head_d  = req_head_q;
    req_cnt_d   = req_cnt_q;
    mem_we      = 1'b0;
    mod_num_d   = mod_num_q;
    mod_rem_d   = mod_rem_q;
    mod_cnt_d   = mod_cnt_q;
    mod_adv_d   = mod_adv_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    otag_d      = otag_q;
    osrv_d      = osrv_q;
    oslot_d     = oslot_q;
    oidle_d     = oidle_q;
    olast_d     = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dur_d   = duration_i;
          tag_d   = query_tag_i;
          pos_d   = '0;
          state_d = (req_type_i == REQ_TICK) ? S_RETIRE : S_SUBMIT;
        end
      end

      // Queue the job or reject it
      S_SUBMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          otag_d  = tag_q;
          osrv_d  = '0;
          oslot_d = '0;
          oidle_d = (busy_q == '0);
          olast_d = 1'b1;
          if (req_cnt_q >= RQC_W'(REQ_DEPTH)) begin
            kind_d = KIND_REJECTED;
          end else begin
            kind_d    = KIND_ACCEPTED;
            mem_we    = 1'b1;
            req_cnt_d = req_cnt_q + RQC_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      // Retire one insertion position of the current slot per step
      S_RETIRE: begin
        if (!ret_hit || out_free) begin
          if (ret_hit) begin
            ent_valid_d[ret_idx] = 1'b0;
            busy_d = (busy_q != '0) ? busy_q - CNT_W'(1) : busy_q;
            if (free_cnt_q < CNT_W'(NUM_SERVERS)) begin
              free_d[free_tail] = ret_idx;
              free_cnt_d = free_cnt_q + CNT_W'(1);
            end
            out_valid_d = 1'b1;
            kind_d  = KIND_RETIRED;
            otag_d  = ent_tag_q[ret_idx];
            osrv_d  = SRVID_W'(ret_idx);
            oslot_d = cur_q;
            oidle_d = (busy_d == '0);
            olast_d = 1'b0;
          end
          pos_d = pos_q + SRV_W'(1);
          if (pos_q == SRV_W'(NUM_SERVERS - 1)) begin
            state_d = S_DISP_CHK;
          end
        end
      end

      // Pair a queued job with a free server, or go advance the slot
      S_DISP_CHK: begin
        if (free_cnt_q != '0 && req_cnt_q != '0) begin
          state_d = S_DISP_LD;
        end else begin
          mod_num_d = MOD_W'(cur_q) + MOD_W'(1);
          mod_rem_d = '0;
          mod_cnt_d = MODC_W'(MOD_W);
          mod_adv_d = 1'b1;
          state_d   = S_MOD;
        end
      end

      S_DISP_LD: begin
        mod_num_d = MOD_W'(cur_q) + MOD_W'(req_rd_q[DUR_W-1:0]);
        mod_rem_d = '0;
        mod_cnt_d = MODC_W'(MOD_W);
        mod_adv_d = 1'b0;
        state_d   = S_MOD;
      end

      // One remainder bit per cycle
      S_MOD: begin
        if (rem_shift >= {1'b0, mod_m}) begin
          mod_rem_d = MD_W'(rem_shift - {1'b0, mod_m});
        end else begin
          mod_rem_d = MD_W'(rem_shift);
        end
        mod_num_d = {mod_num_q[MOD_W-2:0], 1'b0};
        mod_cnt_d = mod_cnt_q - MODC_W'(1);
        if (mod_cnt_q == MODC_W'(1)) begin
          state_d = mod_adv_q ? S_DONE : S_DISPATCH;
        end
      end

      // Place the job on the wheel
      S_DISPATCH: begin
        if (out_free) begin
          ent_valid_d[disp_srv] = 1'b1;
          ent_slot_d[disp_srv]  = mod_rem_q[SLOT_W-1:0];
          ent_tag_d[disp_srv]   = req_rd_q[DUR_W+TAG_W-1:DUR_W];
          ent_ord_d[disp_srv]   = disp_ord;
          busy_d = busy_q + CNT_W'(1);
          free_head_d = (free_head_q == SRV_W'(NUM_SERVERS - 1)) ? '0
                                                                 : free_head_q + SRV_W'(1);
          free_cnt_d  = free_cnt_q - CNT_W'(1);
          req_head_d  = (req_head_q == RQ_W'(REQ_DEPTH - 1)) ? '0 : req_head_q + RQ_W'(1);
          req_cnt_d   = req_cnt_q - RQC_W'(1);
          out_valid_d = 1'b1;
          kind_d  = KIND_DISPATCHED;
          otag_d  = req_rd_q[DUR_W+TAG_W-1:DUR_W];
          osrv_d  = SRVID_W'(disp_srv);
          oslot_d = mod_rem_q[SLOT_W-1:0];
          oidle_d = 1'b0;
          olast_d = 1'b0;
          state_d = S_DISP_CHK;
        end
      end

      // Close the tick and advance the slot
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d  = KIND_DONE;
          otag_d  = '0;
          osrv_d  = '0;
          oslot_d = cur_q;
          oidle_d = (busy_q == '0);
          olast_d = 1'b1;
          cur_d   = mod_rem_q[SLOT_W-1:0];
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_DELAY: md_d = cfg_data_i[MD_W-1:0];
        CFG_NUM_SERVERS: begin
          busy_d      = '0;
          free_head_d = '0;
          free_cnt_d  = ns_eff_new;
          for (int i = 0; i < NUM_SERVERS; i++) begin
            ent_valid_d[i] = 1'b0;
            free_d[i]      = SRV_W'(i);
          end
        end
        default: ;
      endcase
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      md_q        <= MAX_DELAY_RST;
      cur_q       <= '0;
      busy_q      <= '0;
      pos_q       <= '0;
      free_head_q <= '0;
      free_cnt_q  <= CNT_W'(RST_POOL);
      req_head_q  <= '0;
      req_cnt_q   <= '0;
      mod_cnt_q   <= '0;
      mod_adv_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        ent_valid_q[i] <= 1'b0;
        free_q[i]      <= SRV_W'(i);
      end
    end else begin
      state_q     <= state_d;
      md_q        <= md_d;
      cur_q       <= cur_d;
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      req_head_q  <= req_head_d;
      req_cnt_q   <= req_cnt_d;
      mod_cnt_q   <= mod_cnt_d;
      mod_adv_q   <= mod_adv_d;
      out_valid_q <= out_valid_d;
      ent_valid_q <= ent_valid_d;
      free_q      <= free_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dur_q      <= dur_d;
    tag_q      <= tag_d;
    ent_slot_q <= ent_slot_d;
    ent_tag_q  <= ent_tag_d;
    ent_ord_q  <= ent_ord_d;
    mod_num_q  <= mod_num_d;
    mod_rem_q  <= mod_rem_d;
    kind_q     <= kind_d;
    otag_q     <= otag_d;
    osrv_q     <= osrv_d;
    oslot_q    <= oslot_d;
    oidle_q    <= oidle_d;
    olast_q    <= olast_d;
  end

  // Request FIFO memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      req_mem[req_tail] <= {tag_q, dur_q};
    end
    req_rd_q <= req_mem[req_head_q];
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign job_tag_o    = otag_q;
  assign server_id_o  = osrv_q;
  assign slot_o       = oslot_q;
  assign wheel_idle_o = oidle_q;
  assign last_o       = olast_q;

endmodule

[hdl/tmw_checker.sv]
// Port checker for the timing wheel server dispatcher, bound to the top level.
module tmw_checker import tmw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_DAT_W-1:0] cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 req_type_i,
  input logic [DUR_W-1:0]     duration_i,
  input logic [TAG_W-1:0]     query_tag_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [KIND_W-1:0]    kind_o,
  input logic [TAG_W-1:0]     job_tag_o,
  input logic [SRVID_W-1:0]   server_id_o,
  input logic [SLOT_W-1:0]    slot_o,
  input logic                 wheel_idle_o,
  input logic                 last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(job_tag_o) && $stable(kind_o))
    else $error("stalled result changed");

  // Close each tick with a done result
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |-> last_o && job_tag_o == '0 && server_id_o == '0)
    else $error("done result malformed");

  // Retire and dispatch results never end an item
  a_mid_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RETIRED || kind_o == KIND_DISPATCHED) |-> !last_o)
    else $error("retire or dispatch flagged last");

  // Submit results are single and carry no placement
  a_submit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ACCEPTED || kind_o == KIND_REJECTED)
    |-> last_o && server_id_o == '0 && slot_o == '0)
    else $error("submit result malformed");

  // A dispatch leaves the wheel occupied
  a_disp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DISPATCHED |-> !wheel_idle_o)
    else $error("dispatch reported idle wheel");

endmodule

bind timing_wheel_server_dispatcher tmw_checker u_tmw_checker (.*);
